### design/q2e_pkg.sv
// Package for the quaternion to Euler angle unit: widths, gimbal codes and
// the CORDIC arctangent table. No dependencies.
package q2e_pkg;

  localparam int unsigned QW        = 16;
  localparam int unsigned AW        = 32;   // angle accumulator, 2^31 = pi
  localparam int unsigned VW        = 36;   // CORDIC vector width
  localparam int unsigned LimW      = 31;
  localparam int unsigned TabLen    = 24;
  localparam int unsigned CordicDef = 16;
  localparam logic [LimW-1:0] LimitReset = 31'd536869838;

  localparam logic [1:0] GimbalNone  = 2'd0;
  localparam logic [1:0] GimbalNorth = 2'd1;
  localparam logic [1:0] GimbalSouth = 2'd2;

  function automatic logic [AW-1:0] atan_entry(input int unsigned i);
    logic [AW-1:0] r;
    case (i)
      0: r = 32'd536870912;  1: r = 32'd316933406;  2: r = 32'd167458907;
      3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
      6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
      9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
      12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
      15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
      18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
      21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [QW-1:0] round_angle(input logic [AW-1:0] a);
    logic [AW-1:0] s;
    s = a + 32'h0000_8000;
    return s[AW-1:AW-QW];
  endfunction

endpackage

### design/q2e_cordic.sv
// Pipelined vectoring CORDIC arctangent, one iteration per stage.
// Depends on q2e_pkg.
module q2e_cordic import q2e_pkg::*; #(
  parameter int unsigned ITER = CordicDef
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [VW-1:0] y_i,
  input  logic signed [VW-1:0] x_i,
  output logic [AW-1:0]        ang_o
);

  logic signed [VW-1:0] xq [ITER+1];
  logic signed [VW-1:0] yq [ITER+1];
  logic [AW-1:0]        aq [ITER+1];
  logic                 zq [ITER+1];

  // pre-rotation by pi for negative x
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zq[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        xq[0] <= -x_i;
        yq[0] <= -y_i;
        aq[0] <= 32'h8000_0000;
      end else begin
        xq[0] <= x_i;
        yq[0] <= y_i;
        aq[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_it
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zq[i+1] <= zq[i];
        if (yq[i] > 0) begin
          xq[i+1] <= xq[i] + (yq[i] >>> i);
          yq[i+1] <= yq[i] - (xq[i] >>> i);
          aq[i+1] <= aq[i] + atan_entry(i);
        end else begin
          xq[i+1] <= xq[i] - (yq[i] >>> i);
          yq[i+1] <= yq[i] + (xq[i] >>> i);
          aq[i+1] <= aq[i] - atan_entry(i);
        end
      end
    end
  end

  assign ang_o = zq[ITER] ? '0 : aq[ITER];

endmodule

### design/q2e_isqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on q2e_pkg.
module q2e_isqrt import q2e_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] v_i,
  output logic [31:0] r_o
);

  localparam int unsigned N = 32;

  logic [63:0] vq [N+1];
  logic [63:0] rq [N+1];

  always_comb begin
    vq[0] = v_i;
    rq[0] = '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_bit
    localparam logic [63:0] Bit = 64'd1 << (62 - 2*k);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (vq[k] >= rq[k] + Bit) begin
          vq[k+1] <= vq[k] - (rq[k] + Bit);
          rq[k+1] <= (rq[k] >> 1) + Bit;
        end else begin
          vq[k+1] <= vq[k];
          rq[k+1] <= rq[k] >> 1;
        end
      end
    end
  end

  assign r_o = rq[N][31:0];

endmodule

### design/quaternion_to_euler_unit.sv
// Quaternion to Euler angle unit, top level.
// Depends on q2e_pkg, q2e_cordic and q2e_isqrt.
//
// Slave stream s_axis_*: one quaternion word per accepted beat. Master
// stream m_axis_*: one angle word per input word, in order.
// cfg_we_i/cfg_wdata_i write the gimbal lock threshold (unsigned Q1.30).
// The datapath is one pipeline: products, sums and the square root
// radicand (3 stages), 32 square root stages, then CORDIC_ITERATIONS + 1
// CORDIC stages and an output stage.
// A new word can enter every cycle while the pipe advances. The whole pipe
// advances together: when the receiver holds m_axis_tready low and the
// output register is full, the pipe freezes and s_axis_tready drops, so
// nothing is lost or repeated.
// Reset clears all valid bits and loads the default threshold.
module quaternion_to_euler_unit import q2e_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = CordicDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LimW-1:0] cfg_wdata_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w (16 bits each, low first)
  input  logic [63:0]     s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // heading, attitude, bank (16 bits each), gimbal_case (2), zero fill
  output logic [55:0]     m_axis_tdata
);

  localparam int unsigned Depth = 3 + 32 + CORDIC_ITERATIONS + 1 + 1;

  logic [LimW-1:0] limit_q;
  logic            en;
  logic [Depth-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= LimitReset;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: products
  logic signed [31:0] xy_q, zw_q, yw_q, xz_q, xw_q, yz_q, yy_q, zz_q, xx_q;
  logic signed [15:0] x1_q, w1_q;
  logic signed [QW-1:0] xi, yi, zi, wi;
  assign xi = s_axis_tdata[15:0];
  assign yi = s_axis_tdata[31:16];
  assign zi = s_axis_tdata[47:32];
  assign wi = s_axis_tdata[63:48];

  always_ff @(posedge clk_i) begin
    if (en) begin
      xy_q <= xi * yi; zw_q <= zi * wi; yw_q <= yi * wi;
      xz_q <= xi * zi; xw_q <= xi * wi; yz_q <= yi * zi;
      yy_q <= yi * yi; zz_q <= zi * zi; xx_q <= xi * xi;
      x1_q <= xi; w1_q <= wi;
    end
  end

  // stage 2: sums, case, saturation of 2t
  logic signed [VW-1:0] t_c, s_c;
  logic signed [VW-1:0] hn_q, hd_q, bn_q, bd_q, s_q, lx_q, lw_q;
  logic [1:0]  gc_q;
  logic [1:0]  sat_q;  // bit0 +1, bit1 -1
  logic [63:0] rad_q;
  logic signed [VW-1:0] one_q30, lim_s;
  assign one_q30 = VW'(64'sd1 << 30);
  assign lim_s   = VW'(limit_q);
  assign t_c = VW'(xy_q) + VW'(zw_q);
  assign s_c = t_c <<< 1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hn_q <= (VW'(yw_q) - VW'(xz_q)) <<< 1;
      hd_q <= one_q30 - ((VW'(yy_q) + VW'(zz_q)) <<< 1);
      bn_q <= (VW'(xw_q) - VW'(yz_q)) <<< 1;
      bd_q <= one_q30 - ((VW'(xx_q) + VW'(zz_q)) <<< 1);
      lx_q <= VW'(x1_q);
      lw_q <= VW'(w1_q);
      s_q  <= s_c;
      sat_q <= {s_c <= -one_q30, s_c >= one_q30};
      if (t_c > lim_s) gc_q <= GimbalNorth;
      else if (t_c < -lim_s) gc_q <= GimbalSouth;
      else gc_q <= GimbalNone;
    end
  end

  // stage 3: radicand 1 - s^2; unsaturated s fits in 32 bits
  logic signed [31:0] s32;
  logic signed [63:0] sq_c;
  assign s32  = s_q[31:0];
  assign sq_c = s32 * s32;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= (sat_q != 2'b00) ? 64'd0 : (64'd1 << 60) - sq_c;
    end
  end

  // square root delay line for the other operands
  localparam int unsigned SqD = 33;
  logic signed [VW-1:0] dhn [SqD+1], dhd [SqD+1], dbn [SqD+1], dbd [SqD+1];
  logic signed [VW-1:0] ds [SqD+1];
  logic [1:0] dgc [SqD+1], dsat [SqD+1];
  logic [31:0] root;

  always_comb begin
    dhn[0] = hn_q; dhd[0] = hd_q; dbn[0] = bn_q; dbd[0] = bd_q;
    ds[0] = s_q; dgc[0] = gc_q; dsat[0] = sat_q;
  end
  for (genvar k = 0; k < SqD; k++) begin : g_dl
    always_ff @(posedge clk_i) begin
      if (en) begin
        dhn[k+1] <= dhn[k]; dhd[k+1] <= dhd[k];
        dbn[k+1] <= dbn[k]; dbd[k+1] <= dbd[k];
        ds[k+1] <= ds[k]; dgc[k+1] <= dgc[k]; dsat[k+1] <= dsat[k];
      end
    end
  end

  // lock case uses atan2(x, w): swap in at the heading CORDIC input
  logic signed [VW-1:0] lxd [SqD+1], lwd [SqD+1];
  always_comb begin
    lxd[0] = lx_q; lwd[0] = lw_q;
  end
  for (genvar k = 0; k < SqD; k++) begin : g_ld
    always_ff @(posedge clk_i) begin
      if (en) begin
        lxd[k+1] <= lxd[k]; lwd[k+1] <= lwd[k];
      end
    end
  end

  q2e_isqrt u_sqrt (.clk_i, .en_i(en), .v_i(rad_q), .r_o(root));

  logic lock;
  assign lock = dgc[SqD] != GimbalNone;

  logic [AW-1:0] ang_h, ang_a, ang_b;
  q2e_cordic #(.ITER(CORDIC_ITERATIONS)) u_head (
    .clk_i, .en_i(en),
    .y_i(lock ? lxd[SqD] : dhn[SqD]), .x_i(lock ? lwd[SqD] : dhd[SqD]),
    .ang_o(ang_h));
  q2e_cordic #(.ITER(CORDIC_ITERATIONS)) u_att (
    .clk_i, .en_i(en), .y_i(ds[SqD]), .x_i(VW'({1'b0, root})),
    .ang_o(ang_a));
  q2e_cordic #(.ITER(CORDIC_ITERATIONS)) u_bank (
    .clk_i, .en_i(en), .y_i(dbn[SqD]), .x_i(dbd[SqD]), .ang_o(ang_b));

  localparam int unsigned CoD = CORDIC_ITERATIONS + 1;
  logic [1:0] cgc [CoD+1], csat [CoD+1];
  always_comb begin
    cgc[0] = dgc[SqD]; csat[0] = dsat[SqD];
  end
  for (genvar k = 0; k < CoD; k++) begin : g_cd
    always_ff @(posedge clk_i) begin
      if (en) begin
        cgc[k+1] <= cgc[k]; csat[k+1] <= csat[k];
      end
    end
  end

  // output stage
  logic [QW-1:0] h_c, a_c, b_c;
  logic signed [QW-1:0] ar;
  logic [AW-1:0] dbl;
  always_comb begin
    dbl = ang_h << 1;
    ar  = round_angle(ang_a);
    b_c = round_angle(ang_b);
    h_c = round_angle(ang_h);
    a_c = ar;
    if (ar > 16'sd16384) a_c = 16'd16384;
    if (ar < -16'sd16384) a_c = 16'hC000;
    if (csat[CoD][0]) a_c = 16'd16384;
    if (csat[CoD][1]) a_c = 16'hC000;
    case (cgc[CoD])
      GimbalNorth: begin
        h_c = round_angle(dbl); a_c = 16'd16384; b_c = '0;
      end
      GimbalSouth: begin
        h_c = round_angle(-dbl); a_c = 16'hC000; b_c = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) m_axis_tdata <= {6'd0, cgc[CoD], b_c, a_c, h_c};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld_q[Depth-1];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready mismatch");
  a_case: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[49:48] != 2'd3)
    else $error("bad gimbal case");
  a_lock_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[49:48] != GimbalNone |-> m_axis_tdata[47:32] == '0)
    else $error("bank nonzero in lock");

endmodule
